// ===== rtl/cbc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cartridge bank controller package
// Shared types, codes and helper functions for the type-1 bank controller.
// ---------------------------------------------------------------------------
package cbc_pkg;

   localparam int ROM_BANK_BYTES = 16'h4000;
   localparam int RAM_BANK_BYTES = 16'h2000;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      RSP_ZERO = 2'd0,
      RSP_FF   = 2'd1,
      RSP_ROM  = 2'd2,
      RSP_RAM  = 2'd3
   } rsp_kind_type;

   typedef struct packed {
      logic rom_we;
      logic rom_re;
      logic ram_we;
      logic ram_re;
   } mem_ctrl_type;

   localparam logic [7:0] RAM_OFF_DATA = 8'hFF;
   localparam logic [7:0] ZERO_DATA    = 8'h00;

   function automatic logic [6:0] bump_bank(input logic [6:0] b);
      logic [6:0] r;
      r = b;
      if (b[4:0] == 5'd0) begin
         r = b + 7'd1;
      end
      return r;
   endfunction

endpackage

// ===== rtl/cbc_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module cbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/cbc_decode.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bank controller decode
// Holds the bank, enable and mode registers and turns each transfer into
// memory requests and a response kind.
// ---------------------------------------------------------------------------
module cbc_decode #(
   parameter int ROM_BANKS = 8,
   parameter int RAM_BANKS = 4,
   parameter int ROM_AW    = 17,
   parameter int RAM_AW    = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              action,
   input  logic [15:0]             bus_address,
   input  logic [7:0]              write_byte,
   input  logic [16:0]             rom_load_index,
   output cbc_pkg::mem_ctrl_type   ctrl,
   output cbc_pkg::rsp_kind_type   kind,
   output logic [ROM_AW-1:0]       rom_waddr,
   output logic [ROM_AW-1:0]       rom_raddr,
   output logic [RAM_AW-1:0]       ram_addr
);
   import cbc_pkg::*;

   localparam int ROM_BW   = $clog2(ROM_BANKS);
   localparam int RAM_BW   = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
   localparam int ROM_SIZE = ROM_BANKS * ROM_BANK_BYTES;

   logic [6:0]        rom_bank_ff, rom_bank_in;
   logic [1:0]        ram_bank_ff, ram_bank_in;
   logic              ram_enabled_ff, ram_enabled_in;
   logic              banking_mode_ff, banking_mode_in;
   logic [ROM_BW-1:0] rom_wrap [128];
   logic [RAM_BW-1:0] ram_wrap [4];
   logic [1:0]        ram_sel;
   logic              is_write;
   logic              load_ok;

   for (genvar i = 0; i < 128; i++) begin : g_rom_wrap
      assign rom_wrap[i] = ROM_BW'(i % ROM_BANKS);
   end

   for (genvar j = 0; j < 4; j++) begin : g_ram_wrap
      assign ram_wrap[j] = RAM_BW'(j % RAM_BANKS);
   end

   assign is_write  = accept && (action_type'(action) == ACT_WRITE);
   assign ram_sel   = banking_mode_ff ? ram_bank_ff : 2'd0;
   assign ram_addr  = RAM_AW'({ram_wrap[ram_sel], bus_address[12:0]});
   assign rom_raddr = {(bus_address[14] ? rom_wrap[rom_bank_ff] : ROM_BW'(0)),
                       bus_address[13:0]};
   assign rom_waddr = ROM_AW'(rom_load_index);
   assign load_ok   = 32'(rom_load_index) < ROM_SIZE;

   always_comb begin
      rom_bank_in     = rom_bank_ff;
      ram_bank_in     = ram_bank_ff;
      ram_enabled_in  = ram_enabled_ff;
      banking_mode_in = banking_mode_ff;
      if (is_write) begin
         if (bus_address inside {[16'h0000:16'h1FFF]}) begin
            ram_enabled_in = (write_byte & 8'h0A) != 8'h00;
         end else if (bus_address inside {[16'h2000:16'h3FFF]}) begin
            rom_bank_in = bump_bank({rom_bank_ff[6:5], write_byte[4:0]});
         end else if (bus_address inside {[16'h4000:16'h5FFF]}) begin
            if (banking_mode_ff) begin
               ram_bank_in = write_byte[1:0];
            end else begin
               rom_bank_in = bump_bank({write_byte[1:0], rom_bank_ff[4:0]});
            end
         end else if (bus_address inside {[16'h6000:16'h7FFF]}) begin
            banking_mode_in = write_byte[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_ff     <= 7'd1;
         ram_bank_ff     <= 2'd0;
         ram_enabled_ff  <= 1'b0;
         banking_mode_ff <= 1'b0;
      end else begin
         rom_bank_ff     <= rom_bank_in;
         ram_bank_ff     <= ram_bank_in;
         ram_enabled_ff  <= ram_enabled_in;
         banking_mode_ff <= banking_mode_in;
      end
   end

   always_comb begin
      ctrl = '0;
      kind = RSP_ZERO;
      case (action_type'(action))
         ACT_READ: begin
            if (bus_address inside {[16'h0000:16'h7FFF]}) begin
               ctrl.rom_re = accept;
               kind        = RSP_ROM;
            end else if (bus_address inside {[16'hA000:16'hBFFF]}) begin
               if (ram_enabled_ff) begin
                  ctrl.ram_re = accept;
                  kind        = RSP_RAM;
               end else begin
                  kind = RSP_FF;
               end
            end
         end
         ACT_WRITE: begin
            if ((bus_address inside {[16'hA000:16'hBFFF]}) && ram_enabled_ff) begin
               ctrl.ram_we = accept;
            end
         end
         ACT_LOAD: begin
            ctrl.rom_we = accept && load_ok;
         end
         default: begin
            kind = RSP_ZERO;
         end
      endcase
   end

endmodule

// ===== rtl/cbc_resp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bank controller response path
// Tracks the transfer whose memory read is in flight and holds the finished
// result in an output register.
// ---------------------------------------------------------------------------
module cbc_resp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  cbc_pkg::rsp_kind_type kind,
   input  logic [7:0]            rom_q,
   input  logic [7:0]            ram_q,
   input  logic                  rsp_stall,
   output logic                  ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_read_byte
);
   import cbc_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   rsp_kind_type s1_kind_ff;
   logic         out_valid_ff, out_valid_in;
   logic [7:0]   out_data_ff, out_data_in;
   logic         out_free;
   logic         s1_move;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign ready    = !s1_valid_ff || out_free;

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
      case (s1_kind_ff)
         RSP_ROM:  out_data_in = rom_q;
         RSP_RAM:  out_data_in = ram_q;
         RSP_FF:   out_data_in = RAM_OFF_DATA;
         default:  out_data_in = ZERO_DATA;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         s1_kind_ff <= kind;
      end
      if (s1_move) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_read_byte = out_data_ff;

endmodule

// ===== rtl/cartridge_bank_controller_type1.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Type-1 cartridge bank controller
// Serves CPU bus reads and writes and ROM load transfers against a ROM and a
// RAM memory, with bank, enable and mode registers.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  action, bus_address, write_byte,
//                                            rom_load_index
//   rsp      out        rsp_valid/rsp_stall  read_byte
//
// One transfer is taken per cycle while req_stall is low; its result passes
// through the read stage and the output register. After reset the RAM is
// cleared one entry per cycle, all RAM_BANKS * 8192 entries, with req_stall held high.
// The output register lets a new request in while a result waits; a stalled
// result stalls the request side only once the read stage is also full.
// ---------------------------------------------------------------------------
module cartridge_bank_controller_type1 #(
   parameter int ROM_BANKS = 8,
   parameter int RAM_BANKS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_byte,
   input  logic [16:0] req_rom_load_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_byte
);
   import cbc_pkg::*;

   localparam int ROM_DEPTH = ROM_BANKS * ROM_BANK_BYTES;
   localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic              accept;
   logic              ready;
   mem_ctrl_type      ctrl;
   rsp_kind_type      kind;
   logic [ROM_AW-1:0] rom_waddr;
   logic [ROM_AW-1:0] rom_raddr;
   logic [RAM_AW-1:0] ram_addr;
   logic [7:0]        rom_q;
   logic [7:0]        ram_q;
   logic              clearing_ff, clearing_in;
   logic [RAM_AW-1:0] clear_addr_ff, clear_addr_in;
   logic              ram_we;
   logic [RAM_AW-1:0] ram_waddr;
   logic [7:0]        ram_wdata;

   assign req_stall = clearing_ff || !ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + RAM_AW'(1);
         if (clear_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign ram_we    = clearing_ff || ctrl.ram_we;
   assign ram_waddr = clearing_ff ? clear_addr_ff : ram_addr;
   assign ram_wdata = clearing_ff ? ZERO_DATA : req_write_byte;

   cbc_decode #(
      .ROM_BANKS (ROM_BANKS),
      .RAM_BANKS (RAM_BANKS),
      .ROM_AW    (ROM_AW),
      .RAM_AW    (RAM_AW)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .action         (req_action),
      .bus_address    (req_bus_address),
      .write_byte     (req_write_byte),
      .rom_load_index (req_rom_load_index),
      .ctrl           (ctrl),
      .kind           (kind),
      .rom_waddr      (rom_waddr),
      .rom_raddr      (rom_raddr),
      .ram_addr       (ram_addr)
   );

   cbc_ram #(
      .WIDTH (8),
      .DEPTH (ROM_DEPTH)
   ) u_rom (
      .clock (clock),
      .we    (ctrl.rom_we),
      .waddr (rom_waddr),
      .wdata (req_write_byte),
      .re    (ctrl.rom_re),
      .raddr (rom_raddr),
      .rdata (rom_q)
   );

   cbc_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ctrl.ram_re),
      .raddr (ram_addr),
      .rdata (ram_q)
   );

   cbc_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (kind),
      .rom_q         (rom_q),
      .ram_q         (ram_q),
      .rsp_stall     (rsp_stall),
      .ready         (ready),
      .rsp_valid     (rsp_valid),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

// ===== rtl/cbc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bank controller port checker
// Watches the top-level ports for reset behavior, result latency and the
// response handshake.
// ---------------------------------------------------------------------------
module cbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_byte
);

   a_reset_stalls_req: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("Request side must stall while the RAM is being cleared.");

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("No result may be shown right after reset.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("An unstalled transfer must produce its result two cycles later.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_byte))
      else $error("A stalled result must stay valid and unchanged.");

endmodule

bind cartridge_bank_controller_type1 cbc_checker u_checker (.*);
